@@ rtl/bf3_pkg.sv @@
// Shared constants and types of the 3x3 box filter with border pass-through.
`default_nettype none

package bf3_pkg;

	// Default sizes of the top level
	localparam int MAX_COLUMNS_DEF = 256;
	localparam int MAX_ROWS_DEF    = 4096;
	localparam int PIXEL_BITS_DEF  = 8;

	// Configuration port
	localparam int CFG_COLS_W  = 9;
	localparam int CFG_ROWS_W  = 13;
	localparam int CFG_DATA_W  = 13;
	localparam int CFG_INDEX_W = 1;

	localparam logic [CFG_INDEX_W-1:0] REG_FRAME_COLUMNS = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_FRAME_ROWS    = 1'd1;

	localparam int COLUMNS_RESET = 125;
	localparam int ROWS_RESET    = 177;

	// Per-pixel control travelling with a pixel through the pipeline
	typedef struct packed {
		logic has_res;   // pixel (r-1, c-1) exists: row and column both nonzero
		logic interior;  // (r-1, c-1) is off the frame border
		logic last_row;
		logic last_col;
	} bf3_flags_t;

endpackage

`default_nettype wire

@@ rtl/bf3_if.sv @@
// Valid/ready channels: input pixel stream and tagged result stream.
`default_nettype none

interface bf3_pix_if #(
	parameter int PIXEL_BITS = 8
);
	logic                  valid;
	logic                  ready;
	logic [PIXEL_BITS-1:0] pixel_value;

	modport source (output valid, output pixel_value, input ready);
	modport sink   (input valid, input pixel_value, output ready);
endinterface

interface bf3_res_if #(
	parameter int PIXEL_BITS = 8,
	parameter int ROW_BITS   = 12,
	parameter int COL_BITS   = 8
);
	logic                  valid;
	logic                  ready;
	logic [PIXEL_BITS-1:0] smoothed_value;
	logic [ROW_BITS-1:0]   out_row;
	logic [COL_BITS-1:0]   out_column;
	logic                  run_last;

	modport source (output valid, output smoothed_value, output out_row,
		output out_column, output run_last, input ready);
	modport sink   (input valid, input smoothed_value, input out_row,
		input out_column, input run_last, output ready);
endinterface

`default_nettype wire

@@ rtl/bf3_line_store.sv @@
// Two line stores (rows r-2 and r-1) with registered read and a fill count.
`default_nettype none

module bf3_line_store #(
	parameter  int DEPTH      = 256,
	parameter  int PIXEL_BITS = 8,
	localparam int ADDR_BITS  = $clog2(DEPTH)
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  rd_en,
	input  wire logic [ADDR_BITS-1:0]  rd_addr,
	input  wire logic                  wr_en,
	input  wire logic [ADDR_BITS-1:0]  wr_addr,
	input  wire logic [PIXEL_BITS-1:0] wr_pixel,
	output logic      [PIXEL_BITS-1:0] older_pixel,
	output logic      [PIXEL_BITS-1:0] newer_pixel
);

	logic [PIXEL_BITS-1:0] older_mem [DEPTH];
	logic [PIXEL_BITS-1:0] newer_mem [DEPTH];
	logic [PIXEL_BITS-1:0] older_rd_q;
	logic [PIXEL_BITS-1:0] newer_rd_q;
	logic                  rd_hit_q;
	logic [ADDR_BITS:0]    fill_q;

	// Columns are always written as a prefix from zero, so one count tells
	// which entries hold data; the rest read as zero.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			older_rd_q <= older_mem[rd_addr];
			newer_rd_q <= newer_mem[rd_addr];
		end
		// Write back the pixel held in the read registers: age it one row
		if (wr_en) begin
			older_mem[wr_addr] <= newer_pixel;
			newer_mem[wr_addr] <= wr_pixel;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_hit_q <= 1'b0;
			fill_q   <= '0;
		end else begin
			if (rd_en) begin
				rd_hit_q <= ({1'b0, rd_addr} < fill_q);
			end
			if (wr_en && ({1'b0, wr_addr} >= fill_q)) begin
				fill_q <= {1'b0, wr_addr} + (ADDR_BITS + 1)'(1);
			end
		end
	end

	assign older_pixel = rd_hit_q ? older_rd_q : '0;
	assign newer_pixel = rd_hit_q ? newer_rd_q : '0;

endmodule

`default_nettype wire

@@ rtl/bf3_cell.sv @@
// One window column cell: holds three stacked pixels and their sum.
`default_nettype none

module bf3_cell #(
	parameter  int PIXEL_BITS = 8,
	localparam int SUM_BITS   = PIXEL_BITS + 2
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  shift,
	input  wire logic [PIXEL_BITS-1:0] top_in,
	input  wire logic [PIXEL_BITS-1:0] mid_in,
	input  wire logic [PIXEL_BITS-1:0] bot_in,
	output logic      [PIXEL_BITS-1:0] top,
	output logic      [PIXEL_BITS-1:0] mid,
	output logic      [PIXEL_BITS-1:0] bot,
	output logic      [SUM_BITS-1:0]   col_sum
);

	logic [PIXEL_BITS-1:0] top_q;
	logic [PIXEL_BITS-1:0] mid_q;
	logic [PIXEL_BITS-1:0] bot_q;
	logic [SUM_BITS-1:0]   col_sum_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_q     <= '0;
			mid_q     <= '0;
			bot_q     <= '0;
			col_sum_q <= '0;
		end else if (shift) begin
			top_q     <= top_in;
			mid_q     <= mid_in;
			bot_q     <= bot_in;
			col_sum_q <= SUM_BITS'(top_in) + SUM_BITS'(mid_in) + SUM_BITS'(bot_in);
		end
	end

	assign top     = top_q;
	assign mid     = mid_q;
	assign bot     = bot_q;
	assign col_sum = col_sum_q;

endmodule

`default_nettype wire

@@ rtl/bf3_emit.sv @@
// Result stage: divide by nine, expand one pixel into its run of results, output register.
`default_nettype none

module bf3_emit #(
	parameter  int PIXEL_BITS = 8,
	parameter  int ROW_BITS   = 12,
	parameter  int COL_BITS   = 8,
	localparam int SUM_BITS   = PIXEL_BITS + 4
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	output logic                        in_ready,
	input  wire bf3_pkg::bf3_flags_t    flags,
	input  wire logic [ROW_BITS-1:0]    item_row,
	input  wire logic [COL_BITS-1:0]    item_col,
	input  wire logic [SUM_BITS-1:0]    win_sum,
	input  wire logic [PIXEL_BITS-1:0]  w4,
	input  wire logic [PIXEL_BITS-1:0]  w5,
	input  wire logic [PIXEL_BITS-1:0]  w7,
	input  wire logic [PIXEL_BITS-1:0]  w8,
	bf3_res_if.source                   results
);

	import bf3_pkg::*;

	// floor(s / 9) == (s * RECIP) >> SHIFT for every s below 2**SUM_BITS
	localparam int SHIFT      = SUM_BITS + 3;
	localparam int RECIP_BITS = SUM_BITS + 1;
	localparam int PROD_BITS  = SUM_BITS + RECIP_BITS;
	localparam logic [RECIP_BITS-1:0] RECIP = RECIP_BITS'((2 ** SHIFT + 8) / 9);

	// Result slots of one pixel, in emission order
	localparam logic [3:0] SLOT_CENTER = 4'b0001;  // (r-1, c-1)
	localparam logic [3:0] SLOT_BELOW  = 4'b0010;  // (r,   c-1), last row
	localparam logic [3:0] SLOT_RIGHT  = 4'b0100;  // (r-1, c),   last column
	localparam logic [3:0] SLOT_CORNER = 4'b1000;  // (r,   c),   both

	logic                  valid_s3;
	logic [3:0]            mask_s3;
	logic [PROD_BITS-1:0]  prod_s3;
	logic                  interior_s3;
	logic [ROW_BITS-1:0]   row_s3;
	logic [COL_BITS-1:0]   col_s3;
	logic [PIXEL_BITS-1:0] w4_s3;
	logic [PIXEL_BITS-1:0] w5_s3;
	logic [PIXEL_BITS-1:0] w7_s3;
	logic [PIXEL_BITS-1:0] w8_s3;

	logic                  res_valid_q;
	logic [PIXEL_BITS-1:0] value_q;
	logic [ROW_BITS-1:0]   row_q;
	logic [COL_BITS-1:0]   col_q;
	logic                  last_q;

	logic [3:0]            sel;
	logic [3:0]            rest;
	logic                  emit;
	logic                  done;
	logic                  load;
	logic [PIXEL_BITS-1:0] sel_value;
	logic [ROW_BITS-1:0]   sel_row;
	logic [COL_BITS-1:0]   sel_col;

	assign sel      = mask_s3 & (~mask_s3 + 4'd1);
	assign rest     = mask_s3 & ~sel;
	assign emit     = valid_s3 && (!res_valid_q || results.ready);
	assign done     = emit && (rest == 4'd0);
	assign in_ready = !valid_s3 || done;
	assign load     = in_valid && in_ready;

	always_comb begin
		case (sel)
			SLOT_BELOW: begin
				sel_value = w7_s3;
				sel_row   = row_s3;
				sel_col   = col_s3 - COL_BITS'(1);
			end
			SLOT_RIGHT: begin
				sel_value = w5_s3;
				sel_row   = row_s3 - ROW_BITS'(1);
				sel_col   = col_s3;
			end
			SLOT_CORNER: begin
				sel_value = w8_s3;
				sel_row   = row_s3;
				sel_col   = col_s3;
			end
			default: begin
				sel_value = interior_s3 ? prod_s3[SHIFT +: PIXEL_BITS] : w4_s3;
				sel_row   = row_s3 - ROW_BITS'(1);
				sel_col   = col_s3 - COL_BITS'(1);
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (load) begin
			prod_s3     <= PROD_BITS'(win_sum) * PROD_BITS'(RECIP);
			interior_s3 <= flags.interior;
			row_s3      <= item_row;
			col_s3      <= item_col;
			w4_s3       <= w4;
			w5_s3       <= w5;
			w7_s3       <= w7;
			w8_s3       <= w8;
		end
		if (emit) begin
			value_q <= sel_value;
			row_q   <= sel_row;
			col_q   <= sel_col;
			last_q  <= (rest == 4'd0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3    <= 1'b0;
			mask_s3     <= 4'd0;
			res_valid_q <= 1'b0;
		end else begin
			// Pixels on row or column zero carry no result: drop them here
			if (load) begin
				valid_s3 <= flags.has_res;
				mask_s3  <= flags.has_res ?
					{flags.last_col && flags.last_row, flags.last_col, flags.last_row, 1'b1} :
					4'd0;
			end else if (emit) begin
				mask_s3  <= rest;
				valid_s3 <= (rest != 4'd0);
			end
			if (emit) begin
				res_valid_q <= 1'b1;
			end else if (results.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign results.valid          = res_valid_q;
	assign results.smoothed_value = value_q;
	assign results.out_row        = row_q;
	assign results.out_column     = col_q;
	assign results.run_last       = last_q;

endmodule

`default_nettype wire

@@ rtl/box_filter_3x3_border_pass_top.sv @@
// Top level of the 3x3 box filter with border pass-through.
`default_nettype none

// Grey pixels enter in raster order, one per cycle unless the pipeline stalls,
// and every pixel off the frame border leaves as the truncated mean of its 3x3
// neighborhood while border pixels pass unchanged; each result carries its row
// and column and run_last marks the final result caused by one input pixel.
// Results trail the input by one row and one column, and in the last row they
// leave raster order. The input takes one pixel per cycle while each pixel
// causes at most one result and results.ready is high; the single result port
// moves one result per cycle while results.ready is high, so a pixel that
// causes a run of two or four results (last column, last row) holds the input
// until the run has left; it passes s1, s2 and s3 before the output register.
// The line stores need no clearing after reset: unwritten columns read as zero.
module box_filter_3x3_border_pass_top #(
	parameter  int MAX_COLUMNS = bf3_pkg::MAX_COLUMNS_DEF,
	parameter  int MAX_ROWS    = bf3_pkg::MAX_ROWS_DEF,
	parameter  int PIXEL_BITS  = bf3_pkg::PIXEL_BITS_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_write,
	input  wire logic [bf3_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  wire logic [bf3_pkg::CFG_DATA_W-1:0]   cfg_data,
	bf3_pix_if.sink                               pixels,
	bf3_res_if.source                             results
);

	import bf3_pkg::*;

	localparam int COL_BITS      = $clog2(MAX_COLUMNS);
	localparam int ROW_BITS      = $clog2(MAX_ROWS);
	localparam int CELL_SUM_BITS = PIXEL_BITS + 2;
	localparam int SUM_BITS      = PIXEL_BITS + 4;

	function automatic int clamp_last(input int value, input int limit);
		if (value < 3) return 2;
		if (value > limit) return limit - 1;
		return value - 1;
	endfunction

	logic [COL_BITS-1:0]   col_last_q;
	logic [ROW_BITS-1:0]   row_last_q;
	logic [COL_BITS-1:0]   col_q;
	logic [ROW_BITS-1:0]   row_q;

	logic                  valid_s1;
	logic [PIXEL_BITS-1:0] pix_s1;
	logic [COL_BITS-1:0]   col_s1;
	logic [ROW_BITS-1:0]   row_s1;
	bf3_flags_t            flags_s1;

	logic                  valid_s2;
	logic [COL_BITS-1:0]   col_s2;
	logic [ROW_BITS-1:0]   row_s2;
	bf3_flags_t            flags_s2;

	bf3_flags_t            cur_flags;
	logic                  accept;
	logic                  adv_s1;
	logic                  s2_ready;
	logic                  emit_ready;

	logic [PIXEL_BITS-1:0] older_pixel;
	logic [PIXEL_BITS-1:0] newer_pixel;
	logic [PIXEL_BITS-1:0] win_top [4];
	logic [PIXEL_BITS-1:0] win_mid [4];
	logic [PIXEL_BITS-1:0] win_bot [4];
	logic [CELL_SUM_BITS-1:0] win_col_sum [3];
	logic [SUM_BITS-1:0]   win_sum;

	// Configuration: keep the clamped last index of each dimension
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_last_q <= COL_BITS'(clamp_last(COLUMNS_RESET, MAX_COLUMNS));
			row_last_q <= ROW_BITS'(clamp_last(ROWS_RESET, MAX_ROWS));
		end else if (cfg_write) begin
			case (cfg_index)
				REG_FRAME_COLUMNS: col_last_q <= COL_BITS'(clamp_last(
					int'(cfg_data[CFG_COLS_W-1:0]), MAX_COLUMNS));
				REG_FRAME_ROWS: row_last_q <= ROW_BITS'(clamp_last(
					int'(cfg_data[CFG_ROWS_W-1:0]), MAX_ROWS));
				default: ;
			endcase
		end
	end

	always_comb begin
		cur_flags.last_col = (col_q >= col_last_q);
		cur_flags.last_row = (row_q >= row_last_q);
		cur_flags.has_res  = (row_q != '0) && (col_q != '0);
		cur_flags.interior = (row_q >= ROW_BITS'(2)) && (row_q <= row_last_q) &&
			(col_q >= COL_BITS'(2)) && (col_q <= col_last_q);
	end

	assign s2_ready     = !valid_s2 || emit_ready;
	assign adv_s1       = valid_s1 && s2_ready;
	assign pixels.ready = !valid_s1 || s2_ready;
	assign accept       = pixels.valid && pixels.ready;

	// Position of the next input pixel
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (cur_flags.last_col) begin
				col_q <= '0;
				row_q <= cur_flags.last_row ? '0 : row_q + ROW_BITS'(1);
			end else begin
				col_q <= col_q + COL_BITS'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1   <= pixels.pixel_value;
			col_s1   <= col_q;
			row_s1   <= row_q;
			flags_s1 <= cur_flags;
		end
		if (adv_s1) begin
			col_s2   <= col_s1;
			row_s2   <= row_s1;
			flags_s2 <= flags_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end
			if (adv_s1) begin
				valid_s2 <= 1'b1;
			end else if (emit_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	bf3_line_store #(
		.DEPTH      (MAX_COLUMNS),
		.PIXEL_BITS (PIXEL_BITS)
	) u_line_store (
		.clk         (clk),
		.arst_n      (arst_n),
		.rd_en       (accept),
		.rd_addr     (col_q),
		.wr_en       (adv_s1),
		.wr_addr     (col_s1),
		.wr_pixel    (pix_s1),
		.older_pixel (older_pixel),
		.newer_pixel (newer_pixel)
	);

	// Window: cell 2 takes the newest column, cell 0 holds the oldest
	assign win_top[3] = older_pixel;
	assign win_mid[3] = newer_pixel;
	assign win_bot[3] = pix_s1;

	for (genvar i = 0; i < 3; i++) begin : g_cell
		bf3_cell #(
			.PIXEL_BITS (PIXEL_BITS)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.shift   (adv_s1),
			.top_in  (win_top[i+1]),
			.mid_in  (win_mid[i+1]),
			.bot_in  (win_bot[i+1]),
			.top     (win_top[i]),
			.mid     (win_mid[i]),
			.bot     (win_bot[i]),
			.col_sum (win_col_sum[i])
		);
	end

	assign win_sum = SUM_BITS'(win_col_sum[0]) + SUM_BITS'(win_col_sum[1]) +
		SUM_BITS'(win_col_sum[2]);

	bf3_emit #(
		.PIXEL_BITS (PIXEL_BITS),
		.ROW_BITS   (ROW_BITS),
		.COL_BITS   (COL_BITS)
	) u_emit (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (valid_s2),
		.in_ready (emit_ready),
		.flags    (flags_s2),
		.item_row (row_s2),
		.item_col (col_s2),
		.win_sum  (win_sum),
		.w4       (win_mid[1]),
		.w5       (win_mid[2]),
		.w7       (win_bot[1]),
		.w8       (win_bot[2]),
		.results  (results)
	);

endmodule

`default_nettype wire

@@ rtl/bf3_checker.sv @@
// Port-level checks of the box filter result stream, bound to the top level.
`default_nettype none

module bf3_checker #(
	parameter int PIXEL_BITS = 8,
	parameter int ROW_BITS   = 12,
	parameter int COL_BITS   = 8
) (
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  res_valid,
	input wire logic                  res_ready,
	input wire logic [PIXEL_BITS-1:0] smoothed_value,
	input wire logic [ROW_BITS-1:0]   out_row,
	input wire logic [COL_BITS-1:0]   out_column,
	input wire logic                  run_last
);

	logic                xfer;
	logic                open_q;
	logic [COL_BITS-1:0] prev_col_q;
	logic [1:0]          run_cnt_q;

	assign xfer = res_valid && res_ready;

	// Track the run of results caused by one input pixel
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q     <= 1'b0;
			prev_col_q <= '0;
			run_cnt_q  <= 2'd0;
		end else if (xfer) begin
			open_q     <= !run_last;
			prev_col_q <= out_column;
			run_cnt_q  <= run_last ? 2'd0 : run_cnt_q + 2'd1;
		end
	end

	a_reset_quiet: assert property (@(posedge clk) !arst_n |-> !res_valid)
		else $error("result valid during reset");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(smoothed_value) &&
			$stable(out_row) && $stable(out_column) && $stable(run_last))
		else $error("stalled result changed");

	a_run_column: assert property (@(posedge clk) disable iff (!arst_n)
		xfer && open_q |-> (out_column == prev_col_q) ||
			({1'b0, out_column} == {1'b0, prev_col_q} + (COL_BITS + 1)'(1)))
		else $error("result run jumps columns");

	a_run_length: assert property (@(posedge clk) disable iff (!arst_n)
		xfer && (run_cnt_q == 2'd3) |-> run_last)
		else $error("more than four results for one pixel");

endmodule

bind box_filter_3x3_border_pass_top bf3_checker #(
	.PIXEL_BITS (PIXEL_BITS),
	.ROW_BITS   (ROW_BITS),
	.COL_BITS   (COL_BITS)
) u_bf3_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.res_valid      (results.valid),
	.res_ready      (results.ready),
	.smoothed_value (results.smoothed_value),
	.out_row        (results.out_row),
	.out_column     (results.out_column),
	.run_last       (results.run_last)
);

`default_nettype wire
